[design/stable_partition_around_last_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the stable partition block
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef STABLE_PARTITION_AROUND_LAST_MACROS_SVH
`define STABLE_PARTITION_AROUND_LAST_MACROS_SVH

// Same-cycle implication.
`define SPAL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SPAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/spal_pkg.sv]
// ----------------------------------------------------------------------------
// spal_pkg
// Types shared by the partition controller, datapath and top level.
// ----------------------------------------------------------------------------
package spal_pkg;

  localparam int unsigned ValueW = 32;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_READ,
    ST_EVAL,
    ST_PIVOT
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic wr_elem;    // buffer the accepted request
    logic cap_pivot;  // latch pivot, start a run
    logic rd_elem;    // read store at scan index
    logic emit_elem;  // load output register with read element
    logic emit_pivot; // load output register with pivot
    logic idx_inc;    // advance scan index
    logic idx_clr;    // rewind scan index
    logic pass_high;  // switch to the greater-than pass
    logic run_done;   // empty the buffer
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic pivot_in;   // incoming request ends the sequence
    logic cnt_zero;   // nothing buffered
    logic last_idx;   // scan index at last buffered element
    logic qualify;    // read element belongs to the current pass
    logic out_free;   // output register can take a result
  } sts_t;

endpackage

[design/spal_dp.sv]
// ----------------------------------------------------------------------------
// spal_dp
// Element store, pivot, scan index, compare and output register.
// ----------------------------------------------------------------------------
module spal_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [spal_pkg::ValueW-1:0]   in_value_i,
  input  logic                          in_last_i,
  input  spal_pkg::cmd_t                cmd_i,
  output spal_pkg::sts_t                sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [spal_pkg::ValueW-1:0]   out_value_o,
  output logic                          out_pivot_o,
  output logic                          out_end_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [spal_pkg::ValueW-1:0] mem [DEPTH];
  logic [spal_pkg::ValueW-1:0] rdata_q;
  logic [spal_pkg::ValueW-1:0] pivot_q;
  logic [AW-1:0]               cnt_q, cnt_d;
  logic [AW-1:0]               idx_q, idx_d;
  logic [AW-1:0]               k_q, k_d;
  logic                        pass_q, pass_d;
  logic                        ovalid_q, ovalid_d;
  logic [spal_pkg::ValueW-1:0] oval_q;
  logic                        opiv_q;
  logic                        oend_q;
  logic                        le;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_elem) begin
      mem[cnt_q] <= in_value_i;
    end
    if (cmd_i.rd_elem) begin
      rdata_q <= mem[idx_q];
    end
  end

  assign le = $signed(rdata_q) <= $signed(pivot_q);

  always_comb begin
    sts_o.pivot_in = in_last_i || (cnt_q == AW'(DEPTH - 1));
    sts_o.cnt_zero = (cnt_q == '0);
    sts_o.last_idx = (idx_q == cnt_q - AW'(1));
    sts_o.qualify  = pass_q ? !le : le;
    sts_o.out_free = !ovalid_q || out_ready_i;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.run_done) begin
      cnt_d = '0;
    end else if (cmd_i.wr_elem) begin
      cnt_d = cnt_q + AW'(1);
    end

    idx_d = idx_q;
    if (cmd_i.idx_clr || cmd_i.cap_pivot) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + AW'(1);
    end

    pass_d = pass_q;
    if (cmd_i.cap_pivot) begin
      pass_d = 1'b0;
    end else if (cmd_i.pass_high) begin
      pass_d = 1'b1;
    end

    k_d = k_q;
    if (cmd_i.cap_pivot) begin
      k_d = '0;
    end else if (cmd_i.emit_elem || cmd_i.emit_pivot) begin
      k_d = k_q + AW'(1);
    end

    ovalid_d = ovalid_q;
    if (cmd_i.emit_elem || cmd_i.emit_pivot) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      idx_q    <= '0;
      k_q      <= '0;
      pass_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      k_q      <= k_d;
      pass_q   <= pass_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_pivot) begin
      pivot_q <= in_value_i;
    end
    if (cmd_i.emit_elem || cmd_i.emit_pivot) begin
      oval_q <= cmd_i.emit_pivot ? pivot_q : rdata_q;
      opiv_q <= cmd_i.emit_pivot;
      // run holds cnt_q + 1 results, so the last one is number cnt_q
      oend_q <= (k_q == cnt_q);
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_value_o = oval_q;
  assign out_pivot_o = opiv_q;
  assign out_end_o   = oend_q;

endmodule

[design/spal_ctrl.sv]
// ----------------------------------------------------------------------------
// spal_ctrl
// Sequencer: load phase, low pass, pivot, high pass.
// ----------------------------------------------------------------------------
module spal_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  spal_pkg::sts_t sts_i,
  output spal_pkg::cmd_t cmd_o
);

  spal_pkg::state_e state_q, state_d;
  logic             pass_q, pass_d;
  logic             acc;

  assign acc = in_valid_i && (state_q == spal_pkg::ST_LOAD);

  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    case (state_q)
      spal_pkg::ST_LOAD: begin
        if (acc && sts_i.pivot_in) begin
          pass_d  = 1'b0;
          state_d = sts_i.cnt_zero ? spal_pkg::ST_PIVOT : spal_pkg::ST_READ;
        end
      end
      spal_pkg::ST_READ: begin
        state_d = spal_pkg::ST_EVAL;
      end
      spal_pkg::ST_EVAL: begin
        if (!(sts_i.qualify && !sts_i.out_free)) begin
          if (!sts_i.last_idx) begin
            state_d = spal_pkg::ST_READ;
          end else if (!pass_q) begin
            state_d = spal_pkg::ST_PIVOT;
          end else begin
            state_d = spal_pkg::ST_LOAD;
          end
        end
      end
      spal_pkg::ST_PIVOT: begin
        if (sts_i.out_free) begin
          pass_d  = 1'b1;
          state_d = sts_i.cnt_zero ? spal_pkg::ST_LOAD : spal_pkg::ST_READ;
        end
      end
      default: state_d = spal_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      spal_pkg::ST_LOAD: begin
        in_ready_o      = 1'b1;
        cmd_o.wr_elem   = acc && !sts_i.pivot_in;
        cmd_o.cap_pivot = acc && sts_i.pivot_in;
      end
      spal_pkg::ST_READ: begin
        cmd_o.rd_elem = 1'b1;
      end
      spal_pkg::ST_EVAL: begin
        // hold while a qualifying element waits for the output register
        if (!(sts_i.qualify && !sts_i.out_free)) begin
          cmd_o.emit_elem = sts_i.qualify;
          cmd_o.idx_inc   = !sts_i.last_idx;
          cmd_o.idx_clr   = sts_i.last_idx;
          cmd_o.run_done  = sts_i.last_idx && pass_q;
        end
      end
      spal_pkg::ST_PIVOT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_pivot = 1'b1;
          cmd_o.pass_high  = 1'b1;
          cmd_o.idx_clr    = 1'b1;
          cmd_o.run_done   = sts_i.cnt_zero;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spal_pkg::ST_LOAD;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

endmodule

[design/stable_partition_around_last.sv]
// ----------------------------------------------------------------------------
// stable_partition_around_last
// Buffers a run of signed values and replays it partitioned around the last.
// ----------------------------------------------------------------------------
//  channel   dir   tdata            tuser      tlast
//  s_axis    in    value[31:0]      -          last (pivot mark)
//  m_axis    out   value_res[31:0]  is_pivot   end_of_run
//
//  Load: one buffered element per cycle. A run of n buffered elements is then
//  emitted in two store-scan passes of read + compare with the pivot between,
//  each read through the single registered read port of the store.
//  Reset empties the buffer; store contents need no clearing.
//  A stalled m_axis holds the scan; s_axis is refused from the pivot until
//  the scan of the run ends.
// ----------------------------------------------------------------------------
`include "stable_partition_around_last_macros.svh"

module stable_partition_around_last #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] value_res
  output logic        m_axis_tuser_o,   // [0] is_pivot
  output logic        m_axis_tlast_o
);

  spal_pkg::cmd_t cmd;
  spal_pkg::sts_t sts;
  logic           s_acc;
  logic           emit_any;
  logic           m_free;

  spal_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  spal_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_value_i  (s_axis_tdata_i),
    .in_last_i   (s_axis_tlast_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_value_o (m_axis_tdata_o),
    .out_pivot_o (m_axis_tuser_o),
    .out_end_o   (m_axis_tlast_o)
  );

  assign s_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign emit_any = cmd.emit_elem || cmd.emit_pivot;
  assign m_free   = !m_axis_tvalid_o || m_axis_tready_i;

  `SPAL_ASSERT_NOW(a_no_emit_while_loading, emit_any, !s_axis_tready_o, "emit during load")
  `SPAL_ASSERT_NOW(a_emit_into_free_reg, emit_any, m_free, "output overwritten")
  `SPAL_ASSERT_NEXT(a_pivot_closes_input, s_acc && sts.pivot_in, !s_axis_tready_o, "input open")

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives runs of signed values into stable_partition_around_last with random
// gaps and back-pressure, predicts the partitioned order of every run in a
// scoreboard and checks each result against it in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned RAND_REQS = 480;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned DRAIN_CYC = 4 * DEPTH + 40;

  typedef struct packed {
    logic [31:0] value;
    logic        is_pivot;
    logic        end_of_run;
  } part_res_t;

  // Keeps the elements of the open run and the results owed to the receiver.
  class partition_scoreboard;
    logic [31:0] held_q[$];
    part_res_t   owed_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function void note_request(logic [31:0] value, logic last);
      int unsigned total;
      int unsigned k;
      part_res_t   r;
      // Buffer until the pivot mark or until the store is one short of full.
      if (!last && held_q.size() < DEPTH - 1) begin
        held_q.push_back(value);
        return;
      end
      total = held_q.size() + 1;
      k     = 0;
      foreach (held_q[i]) begin
        if ($signed(held_q[i]) <= $signed(value)) begin
          r = '{held_q[i], 1'b0, k == total - 1};
          owed_q.push_back(r);
          k++;
        end
      end
      r = '{value, 1'b1, k == total - 1};
      owed_q.push_back(r);
      k++;
      foreach (held_q[i]) begin
        if ($signed(held_q[i]) > $signed(value)) begin
          r = '{held_q[i], 1'b0, k == total - 1};
          owed_q.push_back(r);
          k++;
        end
      end
      held_q.delete();
    endfunction

    function void check_result(logic [31:0] value, logic is_pivot, logic end_of_run);
      part_res_t want;
      if (owed_q.size() == 0) begin
        $error("unexpected result: value_res=%0d is_pivot=%0b end_of_run=%0b",
               $signed(value), is_pivot, end_of_run);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (want.value !== value) begin
        $error("value_res: expected %0d, got %0d", $signed(want.value), $signed(value));
        errors++;
      end
      if (want.is_pivot !== is_pivot) begin
        $error("is_pivot: expected %0b, got %0b", want.is_pivot, is_pivot);
        errors++;
      end
      if (want.end_of_run !== end_of_run) begin
        $error("end_of_run: expected %0b, got %0b", want.end_of_run, end_of_run);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i  = '0;   // [31:0] value
  logic        s_axis_tlast_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;         // [31:0] value_res
  logic        m_axis_tuser_o;         // [0] is_pivot
  logic        m_axis_tlast_o;

  partition_scoreboard sb = new();

  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;
  int unsigned results_taken = 0;

  stable_partition_around_last #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #2 clk_i = ~clk_i;

  // Record accepted requests before checking results at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      sb.note_request(s_axis_tdata_i, s_axis_tlast_i);
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
    end
  end

  function automatic int unsigned draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1: begin
        case ($urandom_range(0, 4))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = 32'h0000_0000;
          3:       v = 32'hFFFF_FFFF;
          default: v = 32'h0000_0001;
        endcase
      end
      // Narrow range so that ties with the pivot are common.
      2, 3, 4: begin
        v = $urandom_range(0, 8);
        v = v - 32'd4;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Called just after a falling edge; returns just after one.
  task automatic send_request(input logic [31:0] value, input logic last);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= value;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  // Receiver: random stalls, calm stretches and two long hold-offs.
  initial begin
    int unsigned hold;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
      if (results_taken == 40 || results_taken == 250) hold = LONG_HOLD;
      else hold = draw_wait(recv_calm);
      if (hold > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      results_taken++;
      @(negedge clk_i);
    end
  end

  initial begin
    #400_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned len;
    int unsigned kind;
    logic [31:0] corner_vals[5];
    corner_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF};
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Lone pivot.
    send_request(32'd5, 1'b1);
    // Field extremes around a pivot of -1, with a tie.
    foreach (corner_vals[i]) send_request(corner_vals[i], i == 4);
    // Every element equal to the pivot.
    repeat (3) send_request(32'd7, 1'b0);
    send_request(32'd7, 1'b1);
    // Full store without a pivot mark: the last slot becomes the pivot.
    for (int i = 0; i < DEPTH; i++) begin
      send_request((i % 2) ? 32'd100 + i : 32'hFFFF_FF00 + i, 1'b0);
    end

    sent = 0;
    while (sent < RAND_REQS) begin
      kind = $urandom_range(0, 19);
      if (kind < 16) begin
        len = (kind < 10) ? $urandom_range(1, 6) : $urandom_range(1, DEPTH);
        for (int i = 0; i < len; i++) send_request(pick_value(), i == len - 1);
      end else if (kind < 18) begin
        // Overflow the store, then carry on into the next run.
        len = $urandom_range(DEPTH, DEPTH + 6);
        for (int i = 0; i < len; i++) begin
          send_request(pick_value(), (i == len - 1) && ($urandom_range(0, 1) == 1));
        end
      end else begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) send_request(pick_value(), 1'($urandom_range(0, 1)));
      end
      sent += len;
    end
    s_axis_tvalid_i <= 1'b0;

    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    if (sb.owed_q.size() != 0) begin
      $error("%0d expected results never arrived", sb.owed_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
